// File: src/rar_pkg.sv
// rar_pkg: widths, codes and controller/datapath interface types for the
// rational arithmetic reducer. No dependencies; imported by every module.
package rar_pkg;

  localparam int OPERAND_WIDTH = 16;
  localparam int NUM_BITS      = 34;
  localparam int DEN_BITS      = 32;

  // magnitude widths: products, a sum of two products, working width
  localparam int PROD_W  = 2 * OPERAND_WIDTH;
  localparam int SUM_W   = PROD_W + 1;
  localparam int MAG_W   = (SUM_W > NUM_BITS) ? SUM_W : NUM_BITS;
  localparam int SHIFT_W = $clog2(MAG_W + 1);
  localparam int CNT_W   = $clog2(MAG_W);

  typedef enum logic [1:0] {
    MODE_ADD,
    MODE_SUB,
    MODE_MUL,
    MODE_DIV
  } mode_t;

  typedef enum logic [1:0] {
    MUL_OFF,
    MUL_P1,
    MUL_P2,
    MUL_DEN
  } mul_sel_t;

  typedef enum logic [1:0] {
    OUT_NONE,
    OUT_DIV_ZERO,
    OUT_ZERO,
    OUT_REDUCED
  } out_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_P1,
    ST_MUL_P2,
    ST_MUL_DEN,
    ST_SUM,
    ST_CHECK,
    ST_STRIP,
    ST_GCD,
    ST_DIV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic     load;
    mul_sel_t mul_sel;
    logic     sum_en;
    logic     gcd_init;
    logic     strip_en;
    logic     gcd_step;
    logic     div_init;
    logic     div_step;
    out_sel_t out_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic den_zero;
    logic num_zero;
    logic both_even;
    logic gcd_done;
    logic div_last;
  } dp_status_t;

endpackage

// File: src/rar_ctrl.sv
// rar_ctrl: sequencing state machine for the rational arithmetic reducer.
// Depends on rar_pkg; drives rar_dp through dp_cmd_t, reads dp_status_t.
module rar_ctrl
  import rar_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  dp_status_t status,
  output dp_cmd_t    cmd,
  output logic       busy
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) state_next = ST_MUL_P1;
      end
      ST_MUL_P1:  state_next = ST_MUL_P2;
      ST_MUL_P2:  state_next = ST_MUL_DEN;
      ST_MUL_DEN: state_next = ST_SUM;
      ST_SUM:     state_next = ST_CHECK;
      ST_CHECK: begin
        if (status.den_zero || status.num_zero) state_next = ST_IDLE;
        else state_next = ST_STRIP;
      end
      ST_STRIP: begin
        if (!status.both_even) state_next = ST_GCD;
      end
      ST_GCD: begin
        if (status.gcd_done) state_next = ST_DIV;
      end
      ST_DIV: begin
        if (status.div_last) state_next = ST_EMIT;
      end
      ST_EMIT:    state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = (state != ST_IDLE);
    unique case (state)
      ST_IDLE:    cmd.load = start;
      ST_MUL_P1:  cmd.mul_sel = MUL_P1;
      ST_MUL_P2:  cmd.mul_sel = MUL_P2;
      ST_MUL_DEN: cmd.mul_sel = MUL_DEN;
      ST_SUM:     cmd.sum_en = 1'b1;
      ST_CHECK: begin
        priority if (status.den_zero) begin
          cmd.out_sel = OUT_DIV_ZERO;
        end else if (status.num_zero) begin
          cmd.out_sel = OUT_ZERO;
        end else begin
          cmd.gcd_init = 1'b1;
        end
      end
      ST_STRIP:   cmd.strip_en = status.both_even;
      ST_GCD: begin
        if (status.gcd_done) cmd.div_init = 1'b1;
        else cmd.gcd_step = 1'b1;
      end
      ST_DIV:     cmd.div_step = 1'b1;
      ST_EMIT:    cmd.out_sel = OUT_REDUCED;
      default:    cmd = '0;
    endcase
  end

endmodule

// File: src/rar_dp.sv
// rar_dp: datapath of the rational arithmetic reducer: shared multiplier,
// signed-magnitude adder, binary gcd unit and two restoring divider lanes.
// Depends on rar_pkg; commanded by rar_ctrl.
module rar_dp
  import rar_pkg::*;
(
  input  logic                            clk,
  input  logic                            rst,
  input  dp_cmd_t                         cmd,
  output dp_status_t                      status,
  input  logic [1:0]                      mode,
  input  logic signed [OPERAND_WIDTH-1:0] left_num,
  input  logic signed [OPERAND_WIDTH-1:0] left_den,
  input  logic signed [OPERAND_WIDTH-1:0] right_num,
  input  logic signed [OPERAND_WIDTH-1:0] right_den,
  output logic                            done,
  output logic signed [NUM_BITS-1:0]      result_num,
  output logic signed [DEN_BITS-1:0]      result_den,
  output logic                            div_zero
);

  function automatic logic [OPERAND_WIDTH-1:0] mag_of(input logic [OPERAND_WIDTH-1:0] v);
    mag_of = v[OPERAND_WIDTH-1] ? (~v + 1'b1) : v;
  endfunction

  // one restoring step: returns {rem, quo}
  function automatic logic [2*MAG_W-1:0] div_bit(input logic [MAG_W-1:0] rem,
                                                 input logic [MAG_W-1:0] quo,
                                                 input logic [MAG_W-1:0] dvs);
    logic [MAG_W:0] shifted;
    logic [MAG_W:0] diff;
    shifted = {rem, quo[MAG_W-1]};
    diff    = shifted - {1'b0, dvs};
    if (!diff[MAG_W]) div_bit = {diff[MAG_W-1:0], quo[MAG_W-2:0], 1'b1};
    else div_bit = {shifted[MAG_W-1:0], quo[MAG_W-2:0], 1'b0};
  endfunction

  mode_t                    mode_q;
  logic [OPERAND_WIDTH-1:0] ln_mag, ld_mag, rn_mag, rd_mag;
  logic                     ln_neg, ld_neg, rn_neg, rd_neg;

  logic [PROD_W-1:0]        p1, p2, den_mag;
  logic                     p1_neg, p2_neg, den_neg;
  logic [MAG_W-1:0]         num_mag;
  logic                     num_neg;

  logic [MAG_W-1:0]         ga, gb, g;
  logic [SHIFT_W-1:0]       shift_k;
  logic [MAG_W-1:0]         quo_n, quo_d, rem_n, rem_d;
  logic [CNT_W-1:0]         div_cnt;

  logic [OPERAND_WIDTH-1:0] mul_a, mul_b;
  logic                     mul_neg;
  logic [PROD_W-1:0]        mul_p;

  logic [MAG_W-1:0]         p1_ext, p2_ext, sum_mag;
  logic                     p2_sign, sum_neg;

  logic [2*MAG_W-1:0]       step_n, step_d;
  logic [MAG_W-1:0]         num_out, den_out;

  // shared multiplier operand selection
  always_comb begin
    mul_a   = ln_mag;
    mul_b   = rd_mag;
    mul_neg = ln_neg ^ rd_neg;
    unique case (cmd.mul_sel)
      MUL_P1: begin
        if (mode_q == MODE_MUL) begin
          mul_b   = rn_mag;
          mul_neg = ln_neg ^ rn_neg;
        end
      end
      MUL_P2: begin
        mul_a   = rn_mag;
        mul_b   = ld_mag;
        mul_neg = rn_neg ^ ld_neg;
      end
      MUL_DEN: begin
        mul_a = ld_mag;
        if (mode_q == MODE_DIV) begin
          mul_b   = rn_mag;
          mul_neg = ld_neg ^ rn_neg;
        end else begin
          mul_neg = ld_neg ^ rd_neg;
        end
      end
      MUL_OFF: begin
        mul_a = ln_mag;
      end
    endcase
    mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  // signed-magnitude add of the two cross products
  always_comb begin
    p1_ext  = MAG_W'(p1);
    p2_ext  = MAG_W'(p2);
    p2_sign = (mode_q == MODE_SUB) ? ~p2_neg : p2_neg;
    sum_mag = p1_ext;
    sum_neg = p1_neg;
    if (mode_q == MODE_ADD || mode_q == MODE_SUB) begin
      priority if (p1_neg == p2_sign) begin
        sum_mag = p1_ext + p2_ext;
      end else if (p1_ext >= p2_ext) begin
        sum_mag = p1_ext - p2_ext;
      end else begin
        sum_mag = p2_ext - p1_ext;
        sum_neg = p2_sign;
      end
    end
  end

  assign step_n = div_bit(rem_n, quo_n, g);
  assign step_d = div_bit(rem_d, quo_d, g);

  assign num_out = num_neg ? (~quo_n + 1'b1) : quo_n;
  assign den_out = den_neg ? (~quo_d + 1'b1) : quo_d;

  assign status.den_zero  = (den_mag == '0);
  assign status.num_zero  = (num_mag == '0);
  assign status.both_even = !ga[0] && !gb[0];
  assign status.gcd_done  = (ga == '0) || (gb == '0);
  assign status.div_last  = (div_cnt == '0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_q <= mode_t'(mode);
      ln_mag <= mag_of(left_num);
      ld_mag <= mag_of(left_den);
      rn_mag <= mag_of(right_num);
      rd_mag <= mag_of(right_den);
      ln_neg <= left_num[OPERAND_WIDTH-1];
      ld_neg <= left_den[OPERAND_WIDTH-1];
      rn_neg <= right_num[OPERAND_WIDTH-1];
      rd_neg <= right_den[OPERAND_WIDTH-1];
    end

    unique case (cmd.mul_sel)
      MUL_P1: begin
        p1     <= mul_p;
        p1_neg <= mul_neg;
      end
      MUL_P2: begin
        p2     <= mul_p;
        p2_neg <= mul_neg;
      end
      MUL_DEN: begin
        den_mag <= mul_p;
        den_neg <= mul_neg;
      end
      MUL_OFF: begin
      end
    endcase

    if (cmd.sum_en) begin
      num_mag <= sum_mag;
      num_neg <= sum_neg;
    end

    // binary gcd: strip common twos, then shift and subtract
    if (cmd.gcd_init) begin
      ga      <= num_mag;
      gb      <= MAG_W'(den_mag);
      shift_k <= '0;
    end else if (cmd.strip_en) begin
      ga      <= ga >> 1;
      gb      <= gb >> 1;
      shift_k <= shift_k + 1'b1;
    end else if (cmd.gcd_step) begin
      priority if (!ga[0]) begin
        ga <= ga >> 1;
      end else if (!gb[0]) begin
        gb <= gb >> 1;
      end else if (ga >= gb) begin
        ga <= ga - gb;
      end else begin
        gb <= gb - ga;
      end
    end

    if (cmd.div_init) begin
      g       <= (ga | gb) << shift_k;
      quo_n   <= num_mag;
      quo_d   <= MAG_W'(den_mag);
      rem_n   <= '0;
      rem_d   <= '0;
      div_cnt <= CNT_W'(MAG_W - 1);
    end else if (cmd.div_step) begin
      {rem_n, quo_n} <= step_n;
      {rem_d, quo_d} <= step_d;
      div_cnt        <= div_cnt - 1'b1;
    end

    unique case (cmd.out_sel)
      OUT_DIV_ZERO: begin
        result_num <= '0;
        result_den <= '0;
        div_zero   <= 1'b1;
      end
      OUT_ZERO: begin
        result_num <= '0;
        result_den <= DEN_BITS'(1);
        div_zero   <= 1'b0;
      end
      OUT_REDUCED: begin
        result_num <= num_out[NUM_BITS-1:0];
        result_den <= den_out[DEN_BITS-1:0];
        div_zero   <= 1'b0;
      end
      OUT_NONE: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (cmd.out_sel != OUT_NONE);
    end
  end

endmodule

// File: src/rational_arith_reduce.sv
// rational_arith_reduce: top level of the rational add/sub/mul/div unit
// with gcd reduction. Depends on rar_pkg, rar_ctrl and rar_dp.
//
//   channel  | ports                                          | transfer when
//   ---------+------------------------------------------------+----------------
//   request  | mode, left_num, left_den, right_num, right_den | start && !busy
//   result   | result_num, result_den, div_zero               | done (one cycle)
//
// an operation ends at the zero check when the result denominator or
// numerator is zero; otherwise it goes on through the gcd loop, one
// shift or subtract a cycle, and the divider. the shared multiplier forms the
// cross products and denominator in turn, the two divider lanes one bit a cycle.
// busy is high from the cycle after a transfer until done; a new request is
// taken in the cycle done is shown. synchronous reset returns to idle.
module rational_arith_reduce
  import rar_pkg::*;
(
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [1:0]                      mode,
  input  logic signed [OPERAND_WIDTH-1:0] left_num,
  input  logic signed [OPERAND_WIDTH-1:0] left_den,
  input  logic signed [OPERAND_WIDTH-1:0] right_num,
  input  logic signed [OPERAND_WIDTH-1:0] right_den,
  output logic                            busy,
  output logic                            done,
  output logic signed [NUM_BITS-1:0]      result_num,
  output logic signed [DEN_BITS-1:0]      result_den,
  output logic                            div_zero
);

  dp_cmd_t    cmd;
  dp_status_t status;

  rar_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  rar_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .mode       (mode),
    .left_num   (left_num),
    .left_den   (left_den),
    .right_num  (right_num),
    .right_den  (right_den),
    .done       (done),
    .result_num (result_num),
    .result_den (result_den),
    .div_zero   (div_zero)
  );

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while still busy");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted request did not raise busy");

  a_single_result: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

  a_div_zero_fields: assert property (@(posedge clk) disable iff (rst)
    done && div_zero |-> (result_num == '0) && (result_den == '0))
    else $error("divide-by-zero result fields not cleared");

endmodule
